// ----- hdl/hpb_pkg.sv -----
// Package for the histogram percentile boundary block.
// Holds the command codes, register indexes, fixed-point constants and FSM types.
// No dependencies.
`timescale 1ns / 1ps

package hpb_pkg;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [2:0] REG_BIN_ORIGIN     = 3'd0;
  localparam logic [2:0] REG_BIN_WIDTH      = 3'd1;
  localparam logic [2:0] REG_ANCHOR_VALUE   = 3'd2;
  localparam logic [2:0] REG_ANCHOR_BIN     = 3'd3;
  localparam logic [2:0] REG_ANCHOR_PERCENT = 3'd4;

  localparam logic [23:0] FULL_PCT        = 24'd10000000;
  localparam logic [47:0] RAW_MAX_DEFAULT = 48'd65536000000;
  localparam logic [47:0] MAX48           = 48'hFFFF_FFFF_FFFF;

  localparam int DIV_STEPS = 88;

  typedef enum logic [9:0] {
    S_CLR  = 10'b00_0000_0001,
    S_IDLE = 10'b00_0000_0010,
    S_LD   = 10'b00_0000_0100,
    S_SCAN = 10'b00_0000_1000,
    S_MUL  = 10'b00_0001_0000,
    S_DIV  = 10'b00_0010_0000,
    S_WALK = 10'b00_0100_0000,
    S_EDGE = 10'b00_1000_0000,
    S_RAW  = 10'b01_0000_0000,
    S_RES  = 10'b10_0000_0000
  } state_t;

  typedef enum logic [6:0] {
    J_RAW = 7'b000_0001,
    J_SUM = 7'b000_0010,
    J_T   = 7'b000_0100,
    J_D   = 7'b000_1000,
    J_LP  = 7'b001_0000,
    J_RP  = 7'b010_0000,
    J_V   = 7'b100_0000
  } job_t;

endpackage

// ----- hdl/histogram_percentile_boundary_top.sv -----
// Histogram percentile boundary: bin counts in one synchronous memory, a serial
// multiply unit and a shared restoring divider. Depends on hpb_pkg.
// A load reads the old count and writes the new one; a clear rewrites every bin. A query
// at percentile 0 scans all bins for the last empty one; other queries below the anchor
// percentile walk the bins and run up to four multiply-divide passes, and anchored queries
// add a sum scan and one more pass. One item is processed at a time.
// Reset is synchronous; it starts a clearing pass over the memory while in_stall
// stays high.
`timescale 1ns / 1ps

module histogram_percentile_boundary_top #(
  parameter int NUM_BINS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [9:0]  in_bin_index,
  input  logic [31:0] in_bin_count,
  input  logic [23:0] in_percentile,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] out_boundary,
  output logic [23:0] out_precision,
  output logic        out_precision_valid,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  import hpb_pkg::*;

  localparam int AW = $clog2(NUM_BINS);
  localparam int CW = $clog2(NUM_BINS + 1);
  localparam int TW = 32 + AW;

  logic [31:0] mem [NUM_BINS];

  state_t          state_r, state_nxt;
  job_t            job_r, job_nxt;
  logic [CW-1:0]   idx_r, idx_nxt, didx_r, zidx_r, zidx_nxt, eidx_r, eidx_nxt;
  logic            dv_r, zf_r, zf_nxt, anch_r, anch_nxt;
  logic [31:0]     rd_data_r;
  logic [TW-1:0]   acc_r, acc_nxt, total_r, total_nxt;
  logic [23:0]     q_r, q_nxt, lp_r, lp_nxt, mul_a_r, mul_a_nxt;
  logic [63:0]     t_r, t_nxt, count_r, count_nxt, desired_r, desired_nxt;
  logic [63:0]     mul_b_r, mul_b_nxt, div_d_r, div_d_nxt, rem_r, rem_nxt;
  logic [87:0]     prod_r, prod_nxt;
  logic            mstep_r, mstep_nxt;
  logic [6:0]      dcnt_r, dcnt_nxt;
  logic [47:0]     edge_r, res_bnd_r, res_bnd_nxt;
  logic [23:0]     res_prec_r, res_prec_nxt;
  logic            res_pv_r, res_pv_nxt;
  logic            out_valid_r;
  logic [47:0]     out_bnd_r;
  logic [23:0]     out_prec_r;
  logic            out_pv_r;
  logic [AW-1:0]   ld_idx_r, ld_idx_nxt, rd_addr;
  logic [31:0]     ld_cnt_r, ld_cnt_nxt;
  logic [31:0]     bin_origin_r, bin_width_r;
  logic [47:0]     anchor_value_r;
  logic [9:0]      anchor_bin_r;
  logic [23:0]     anchor_percent_r;

  logic            accept, rd_issue, mem_we, out_load;
  logic [AW-1:0]   mem_wa;
  logic [31:0]     mem_wd;
  logic [23:0]     ap;
  logic [31:0]     bsel;
  logic [55:0]     pp;
  logic [64:0]     rem_sh;
  logic [65:0]     diff;
  logic            ge;
  logic [63:0]     csum, tq;
  logic [49:0]     edge_sum;
  logic [48:0]     vsum;
  logic [23:0]     span, num;
  logic [CW-1:0]   anchor_start;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_boundary = out_bnd_r;
  assign out_precision = out_prec_r;
  assign out_precision_valid = out_pv_r;

  assign ap = (anchor_percent_r > FULL_PCT) ? FULL_PCT : anchor_percent_r;
  assign anchor_start = (32'(anchor_bin_r) < 32'(NUM_BINS)) ? CW'(anchor_bin_r)
                                                             : CW'(NUM_BINS);
  assign rd_issue = ((state_r == S_SCAN) || (state_r == S_WALK)) &&
                    (idx_r < CW'(NUM_BINS));
  assign rd_addr = (state_r == S_IDLE) ? AW'(in_bin_index) : idx_r[AW-1:0];

  assign bsel   = mstep_r ? mul_b_r[63:32] : mul_b_r[31:0];
  assign pp     = {32'b0, mul_a_r} * {24'b0, bsel};
  assign rem_sh = {rem_r, prod_r[87]};
  assign diff   = {1'b0, rem_sh} - {2'b0, div_d_r};
  assign ge     = !diff[65];
  assign csum   = count_r + 64'(rd_data_r);
  assign tq     = (prod_r[87:64] != 24'd0) ? {64{1'b1}} : prod_r[63:0];
  assign edge_sum = 50'(bin_origin_r) + 50'(eidx_r) * 50'(bin_width_r);
  assign vsum   = {1'b0, edge_r} + 49'(prod_r[31:0]);
  assign span   = prod_r[23:0] - lp_r;
  assign num    = (q_r > lp_r) ? (((q_r - lp_r) > span) ? span : (q_r - lp_r)) : 24'd0;

  always_comb begin
    state_nxt = state_r;
    job_nxt = job_r;
    idx_nxt = idx_r;
    zidx_nxt = zidx_r;
    zf_nxt = zf_r;
    eidx_nxt = eidx_r;
    anch_nxt = anch_r;
    acc_nxt = acc_r;
    total_nxt = total_r;
    q_nxt = q_r;
    lp_nxt = lp_r;
    t_nxt = t_r;
    count_nxt = count_r;
    desired_nxt = desired_r;
    mul_a_nxt = mul_a_r;
    mul_b_nxt = mul_b_r;
    div_d_nxt = div_d_r;
    rem_nxt = rem_r;
    prod_nxt = prod_r;
    mstep_nxt = mstep_r;
    dcnt_nxt = dcnt_r;
    res_bnd_nxt = res_bnd_r;
    res_prec_nxt = res_prec_r;
    res_pv_nxt = res_pv_r;
    ld_idx_nxt = ld_idx_r;
    ld_cnt_nxt = ld_cnt_r;
    mem_we = 1'b0;
    mem_wa = idx_r[AW-1:0];
    mem_wd = 32'd0;
    out_load = 1'b0;
    unique case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == CW'(NUM_BINS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_bnd_nxt = 48'd0;
          res_prec_nxt = 24'd0;
          res_pv_nxt = 1'b0;
          if (in_cmd == CMD_LOAD) begin
            if (32'(in_bin_index) < 32'(NUM_BINS)) begin
              ld_idx_nxt = AW'(in_bin_index);
              ld_cnt_nxt = in_bin_count;
              state_nxt = S_LD;
            end
          end else if (in_cmd == CMD_CLEAR) begin
            total_nxt = '0;
            idx_nxt = '0;
            state_nxt = S_CLR;
          end else if (in_cmd == CMD_QUERY) begin
            q_nxt = FULL_PCT - in_percentile;
            priority if (in_percentile == 24'd0) begin
              job_nxt = J_RAW;
              zf_nxt = 1'b0;
              idx_nxt = '0;
              state_nxt = S_SCAN;
            end else if (in_percentile >= FULL_PCT) begin
              state_nxt = S_RES;
            end else if (in_percentile >= ap) begin
              res_bnd_nxt = anchor_value_r;
              state_nxt = S_RES;
            end else if (anchor_value_r != 48'd0) begin
              anch_nxt = 1'b1;
              job_nxt = J_SUM;
              acc_nxt = '0;
              idx_nxt = anchor_start;
              state_nxt = S_SCAN;
            end else begin
              anch_nxt = 1'b0;
              t_nxt = 64'(total_r);
              count_nxt = '0;
              if (total_r == '0) begin
                state_nxt = S_RES;
              end else begin
                mul_a_nxt = FULL_PCT - in_percentile;
                mul_b_nxt = 64'(total_r);
                div_d_nxt = 64'(FULL_PCT);
                mstep_nxt = 1'b0;
                job_nxt = J_D;
                state_nxt = S_MUL;
              end
            end
          end
        end
      end
      S_LD: begin
        mem_we = 1'b1;
        mem_wa = ld_idx_r;
        mem_wd = ld_cnt_r;
        total_nxt = total_r - TW'(rd_data_r) + TW'(ld_cnt_r);
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (rd_issue) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (dv_r) begin
          if (job_r == J_RAW) begin
            if (rd_data_r == 32'd0) begin
              zf_nxt = 1'b1;
              zidx_nxt = didx_r;
            end
          end else begin
            acc_nxt = acc_r + TW'(rd_data_r);
          end
        end else if (!rd_issue) begin
          if (job_r == J_RAW) begin
            eidx_nxt = zidx_r + 1'b1;
            state_nxt = S_EDGE;
          end else begin
            mul_a_nxt = FULL_PCT;
            mul_b_nxt = 64'(acc_r);
            div_d_nxt = 64'(ap);
            mstep_nxt = 1'b0;
            job_nxt = J_T;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        mstep_nxt = 1'b1;
        if (!mstep_r) begin
          prod_nxt = 88'(pp);
        end else begin
          prod_nxt = prod_r + {pp, 32'b0};
          rem_nxt = '0;
          dcnt_nxt = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (dcnt_r != 7'(DIV_STEPS)) begin
          rem_nxt = ge ? diff[63:0] : rem_sh[63:0];
          prod_nxt = {prod_r[86:0], ge};
          dcnt_nxt = dcnt_r + 1'b1;
        end else begin
          mstep_nxt = 1'b0;
          state_nxt = S_MUL;
          unique case (job_r)
            J_T: begin
              t_nxt = tq;
              if (tq == 64'd0) begin
                state_nxt = S_RES;
              end else begin
                count_nxt = tq - 64'(acc_r);
                mul_a_nxt = q_r;
                mul_b_nxt = tq;
                div_d_nxt = 64'(FULL_PCT);
                job_nxt = J_D;
              end
            end
            J_D: begin
              desired_nxt = prod_r[63:0];
              idx_nxt = anch_r ? anchor_start : '0;
              state_nxt = S_WALK;
            end
            J_LP: begin
              lp_nxt = prod_r[23:0];
              mul_a_nxt = FULL_PCT;
              mul_b_nxt = count_r;
              div_d_nxt = t_r;
              job_nxt = J_RP;
            end
            J_RP: begin
              res_pv_nxt = 1'b1;
              res_prec_nxt = {1'b0, span[23:1]};
              if (span == 24'd0) begin
                res_bnd_nxt = edge_r;
                state_nxt = S_RES;
              end else begin
                mul_a_nxt = num;
                mul_b_nxt = 64'(bin_width_r);
                div_d_nxt = 64'(span);
                job_nxt = J_V;
              end
            end
            J_V: begin
              res_bnd_nxt = (vsum > 49'(MAX48)) ? MAX48 : vsum[47:0];
              state_nxt = S_RES;
            end
            default: begin
              state_nxt = S_RES;
            end
          endcase
        end
      end
      S_WALK: begin
        if (rd_issue) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (dv_r) begin
          count_nxt = csum;
          if (csum >= desired_r) begin
            eidx_nxt = didx_r;
            mul_a_nxt = FULL_PCT;
            mul_b_nxt = count_r;
            div_d_nxt = t_r;
            mstep_nxt = 1'b0;
            job_nxt = J_LP;
            state_nxt = S_MUL;
          end
        end else if (!rd_issue) begin
          state_nxt = S_RES;
        end
      end
      S_EDGE: begin
        state_nxt = S_RAW;
      end
      S_RAW: begin
        res_bnd_nxt = zf_r ? edge_r : RAW_MAX_DEFAULT;
        state_nxt = S_RES;
      end
      S_RES: begin
        if (!out_valid_r || !out_stall) begin
          out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      job_r <= J_RAW;
      idx_r <= '0;
      dv_r <= 1'b0;
      total_r <= '0;
      out_valid_r <= 1'b0;
      bin_origin_r <= 32'd0;
      bin_width_r <= 32'd65536;
      anchor_value_r <= 48'd0;
      anchor_bin_r <= 10'd0;
      anchor_percent_r <= FULL_PCT;
    end else begin
      state_r <= state_nxt;
      job_r <= job_nxt;
      idx_r <= idx_nxt;
      dv_r <= rd_issue;
      total_r <= total_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_BIN_ORIGIN:     bin_origin_r <= cfg_data[31:0];
          REG_BIN_WIDTH:      bin_width_r <= cfg_data[31:0];
          REG_ANCHOR_VALUE:   anchor_value_r <= cfg_data;
          REG_ANCHOR_BIN:     anchor_bin_r <= cfg_data[9:0];
          REG_ANCHOR_PERCENT: anchor_percent_r <= cfg_data[23:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    didx_r <= idx_r;
    zidx_r <= zidx_nxt;
    zf_r <= zf_nxt;
    eidx_r <= eidx_nxt;
    anch_r <= anch_nxt;
    acc_r <= acc_nxt;
    q_r <= q_nxt;
    lp_r <= lp_nxt;
    t_r <= t_nxt;
    count_r <= count_nxt;
    desired_r <= desired_nxt;
    mul_a_r <= mul_a_nxt;
    mul_b_r <= mul_b_nxt;
    div_d_r <= div_d_nxt;
    rem_r <= rem_nxt;
    prod_r <= prod_nxt;
    mstep_r <= mstep_nxt;
    dcnt_r <= dcnt_nxt;
    res_bnd_r <= res_bnd_nxt;
    res_prec_r <= res_prec_nxt;
    res_pv_r <= res_pv_nxt;
    ld_idx_r <= ld_idx_nxt;
    ld_cnt_r <= ld_cnt_nxt;
    edge_r <= (edge_sum > 50'(MAX48)) ? MAX48 : edge_sum[47:0];
    if (out_load) begin
      out_bnd_r <= res_bnd_r;
      out_prec_r <= res_prec_r;
      out_pv_r <= res_pv_r;
    end
  end

endmodule

// ----- hdl/hpb_checker.sv -----
// Port-level checker for the histogram percentile boundary block, with its bind.
// Depends on histogram_percentile_boundary_top.
`timescale 1ns / 1ps

module hpb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [47:0] out_boundary,
  input logic [23:0] out_precision,
  input logic        out_precision_valid
);

  a_reset_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled during the clearing pass after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_boundary))
    else $error("stalled boundary changed");

  a_prec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_precision_valid |-> out_precision == 24'd0)
    else $error("precision nonzero without a found bin");

endmodule

bind histogram_percentile_boundary_top hpb_checker u_hpb_checker (.*);

// ----- tb/histogram_percentile_boundary_top_tb.sv -----
// Testbench for the histogram percentile boundary block: loads, clears and queries
// are driven through a queue and every query result is checked against a predictor.
// Depends on hpb_pkg and histogram_percentile_boundary_top.
`timescale 1ns / 1ps

module histogram_percentile_boundary_top_tb;
  import hpb_pkg::*;

  localparam int NBINS = 1024;
  localparam longint unsigned FULL = 64'd10000000;
  localparam longint unsigned CYCLE_LIMIT = 64'd40000000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [9:0]  bin_index;
    logic [31:0] bin_count;
    logic [23:0] percentile;
  } hist_item_t;

  typedef struct packed {
    logic [47:0] boundary;
    logic [23:0] precision;
    logic        precision_valid;
  } boundary_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [9:0]  in_bin_index;
  logic [31:0] in_bin_count;
  logic [23:0] in_percentile;
  logic        out_valid;
  logic        out_stall;
  logic [47:0] out_boundary;
  logic [23:0] out_precision;
  logic        out_precision_valid;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;
  logic        in_fire;

  hist_item_t       pending_items[$];
  boundary_result_t expected_results[$];
  int               send_idle_pct;
  int               recv_stall_pct;
  int               error_count;
  longint unsigned  cycle_count;

  logic [31:0]     m_bins[NBINS];
  longint unsigned m_total;
  longint unsigned m_origin, m_width, m_anchor_value, m_anchor_bin, m_anchor_pct;

  histogram_percentile_boundary_top #(.NUM_BINS(NBINS)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_bin_index(in_bin_index), .in_bin_count(in_bin_count),
    .in_percentile(in_percentile),
    .out_valid(out_valid), .out_stall(out_stall), .out_boundary(out_boundary),
    .out_precision(out_precision), .out_precision_valid(out_precision_valid),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic longint unsigned scaled_div(longint unsigned a, longint unsigned b,
                                                 longint unsigned c);
    logic [127:0] prod;
    logic [127:0] quo;
    if (c == 0) return 64'hFFFF_FFFF_FFFF_FFFF;
    prod = 128'(a) * 128'(b);
    quo = prod / 128'(c);
    if (quo[127:64] != 0) return 64'hFFFF_FFFF_FFFF_FFFF;
    return quo[63:0];
  endfunction

  function automatic longint unsigned bin_edge(longint unsigned i);
    longint unsigned e;
    e = m_origin + i * m_width;
    return (e > 64'(MAX48)) ? 64'(MAX48) : e;
  endfunction

  function automatic boundary_result_t predict_boundary(longint unsigned p);
    boundary_result_t r;
    longint unsigned ap, q, t, cnt, target, first, above, c, lp, rp, span, num, v;
    r = '0;
    ap = (m_anchor_pct > FULL) ? FULL : m_anchor_pct;
    if (p == 0) begin
      r.boundary = RAW_MAX_DEFAULT;
      for (int i = NBINS - 1; i >= 0; i--) begin
        if (m_bins[i] == 0) begin
          r.boundary = 48'(bin_edge(64'(i + 1)));
          break;
        end
      end
      return r;
    end
    if (p >= FULL) return r;
    if (p >= ap) begin
      r.boundary = 48'(m_anchor_value);
      return r;
    end
    q = FULL - p;
    first = 0;
    t = m_total;
    cnt = 0;
    if (m_anchor_value > 0) begin
      above = 0;
      first = m_anchor_bin;
      for (longint unsigned i = first; i < NBINS; i++) above += m_bins[i];
      t = scaled_div(above, FULL, ap);
      cnt = t - above;
    end
    if (t == 0) return r;
    target = scaled_div(q, t, FULL);
    for (longint unsigned i = first; i < NBINS; i++) begin
      c = m_bins[i];
      cnt += c;
      if (cnt >= target) begin
        lp = scaled_div(FULL, cnt - c, t);
        rp = scaled_div(FULL, cnt, t);
        span = rp - lp;
        num = (q > lp) ? q - lp : 0;
        if (num > span) num = span;
        v = bin_edge(i);
        if (span != 0) v += (num * m_width) / span;
        r.boundary = (v > 64'(MAX48)) ? MAX48 : v[47:0];
        r.precision = span[24:1];
        r.precision_valid = 1'b1;
        return r;
      end
    end
    return r;
  endfunction

  task automatic apply_item(hist_item_t it);
    case (it.cmd)
      CMD_LOAD: begin
        m_total = m_total - m_bins[it.bin_index] + it.bin_count;
        m_bins[it.bin_index] = it.bin_count;
      end
      CMD_CLEAR: begin
        foreach (m_bins[i]) m_bins[i] = '0;
        m_total = 0;
      end
      CMD_QUERY: expected_results.push_back(predict_boundary(it.percentile));
      default: ;
    endcase
  endtask

  always @(negedge clk) begin
    if (in_fire) begin
      apply_item(pending_items.pop_front());
    end
    if (pending_items.size() > 0 &&
        ((in_valid && !in_fire) || $urandom_range(99) >= send_idle_pct)) begin
      in_valid <= 1'b1;
      in_cmd <= pending_items[0].cmd;
      in_bin_index <= pending_items[0].bin_index;
      in_bin_count <= pending_items[0].bin_count;
      in_percentile <= pending_items[0].percentile;
    end else begin
      in_valid <= 1'b0;
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // The input handshake is sampled at the rising edge; the driver commits the
  // transaction at the following falling edge.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction boundary=%0d", out_boundary);
        error_count++;
      end else begin
        boundary_result_t e;
        e = expected_results.pop_front();
        if (out_boundary !== e.boundary) begin
          $error("boundary expected %0d actual %0d", e.boundary, out_boundary);
          error_count++;
        end
        if (out_precision !== e.precision) begin
          $error("precision expected %0d actual %0d", e.precision, out_precision);
          error_count++;
        end
        if (out_precision_valid !== e.precision_valid) begin
          $error("precision_valid expected %0d actual %0d", e.precision_valid,
                 out_precision_valid);
          error_count++;
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_item(logic [1:0] cmd, logic [9:0] idx, logic [31:0] cnt,
                           logic [23:0] p);
    hist_item_t it;
    it.cmd = cmd;
    it.bin_index = idx;
    it.bin_count = cnt;
    it.percentile = p;
    pending_items.push_back(it);
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_BIN_ORIGIN:     m_origin = data[31:0];
      REG_BIN_WIDTH:      m_width = data[31:0];
      REG_ANCHOR_VALUE:   m_anchor_value = data;
      REG_ANCHOR_BIN:     m_anchor_bin = data[9:0];
      REG_ANCHOR_PERCENT: m_anchor_pct = data[23:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [23:0] rand_pct();
    case ($urandom_range(9))
      0: return 24'd0;
      1: return 24'(FULL);
      2: return 24'hFFFFFF;
      3: return 24'($urandom_range(10, 0) + FULL - 5);
      default: return 24'($urandom_range(10000000, 1));
    endcase
  endfunction

  function automatic logic [31:0] rand_count();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFFFFFF;
      2: return $urandom;
      default: return 32'($urandom_range(1000));
    endcase
  endfunction

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) begin
      int r;
      r = $urandom_range(99);
      if (r < 60)
        push_item(CMD_LOAD, (($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(15))) |
                  (($urandom_range(7) == 0) ? 10'h3F0 : 10'h0), rand_count(), 24'($urandom));
      else if (r < 92) push_item(CMD_QUERY, 10'($urandom), $urandom, rand_pct());
      else if (r < 95) push_item(CMD_CLEAR, 10'($urandom), $urandom, 24'($urandom));
      else push_item(2'd3, 10'($urandom), $urandom, 24'($urandom));
    end
  endtask

  initial begin
    foreach (m_bins[i]) m_bins[i] = '0;
    m_total = 0;
    m_origin = 0;
    m_width = 65536;
    m_anchor_value = 0;
    m_anchor_bin = 0;
    m_anchor_pct = FULL;
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_fire = 1'b0;
    in_valid = 1'b0;
    in_cmd = '0;
    in_bin_index = '0;
    in_bin_count = '0;
    in_percentile = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    push_item(CMD_QUERY, 10'd0, 32'd0, 24'd0);
    push_item(CMD_QUERY, 10'd0, 32'd0, 24'd5000000);
    push_item(CMD_LOAD, 10'd0, 32'd10, 24'd0);
    push_item(CMD_LOAD, 10'd1, 32'd0, 24'd0);
    push_item(CMD_LOAD, 10'd2, 32'd30, 24'hFFFFFF);
    push_item(CMD_LOAD, 10'd1023, 32'hFFFFFFFF, 24'd0);
    push_item(CMD_QUERY, 10'd0, 32'd0, 24'd0);
    push_item(CMD_QUERY, 10'd0, 32'd0, 24'd1);
    push_item(CMD_QUERY, 10'd0, 32'd0, 24'd9999999);
    push_item(CMD_QUERY, 10'd0, 32'd0, 24'(FULL));
    push_item(CMD_QUERY, 10'd0, 32'd0, 24'hFFFFFF);
    push_item(CMD_QUERY, 10'd0, 32'd0, 24'd2500000);
    push_item(2'd3, 10'h3FF, 32'hFFFFFFFF, 24'hFFFFFF);
    push_item(CMD_LOAD, 10'd1023, 32'd0, 24'd0);
    push_item(CMD_QUERY, 10'd0, 32'd0, 24'd7000000);
    push_item(CMD_CLEAR, 10'd0, 32'd0, 24'd0);
    push_item(CMD_QUERY, 10'd0, 32'd0, 24'd5000000);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      case (ph)
        0: ;
        1: begin
          write_reg(REG_BIN_ORIGIN, 48'hFFFFFFFF);
          write_reg(REG_BIN_WIDTH, 48'hFFFFFFFF);
        end
        2: begin
          write_reg(REG_BIN_ORIGIN, 48'd1000);
          write_reg(REG_BIN_WIDTH, 48'd1);
          write_reg(REG_ANCHOR_VALUE, 48'd123456);
          write_reg(REG_ANCHOR_BIN, 48'd2);
          write_reg(REG_ANCHOR_PERCENT, 48'd6000000);
        end
        3: begin
          write_reg(REG_ANCHOR_VALUE, MAX48);
          write_reg(REG_ANCHOR_BIN, 48'd0);
          write_reg(REG_ANCHOR_PERCENT, 48'd1);
        end
        4: begin
          write_reg(REG_ANCHOR_PERCENT, 48'hFFFFFF);
          write_reg(REG_ANCHOR_BIN, 48'd1023);
          write_reg(REG_BIN_WIDTH, 48'd65536);
        end
        5: begin
          write_reg(REG_ANCHOR_PERCENT, 48'd0);
          write_reg(REG_ANCHOR_VALUE, 48'd0);
          write_reg(REG_BIN_ORIGIN, 48'd0);
        end
        6: begin
          write_reg(REG_ANCHOR_PERCENT, 48'($urandom_range(10000000, 1)));
          write_reg(REG_ANCHOR_VALUE, {16'($urandom), 32'($urandom)});
          write_reg(REG_ANCHOR_BIN, 48'($urandom_range(15)));
          write_reg(REG_BIN_WIDTH, 48'($urandom_range(200000, 1)));
        end
        default: begin
          write_reg(REG_ANCHOR_VALUE, 48'd0);
          write_reg(REG_ANCHOR_PERCENT, 48'(FULL));
          write_reg(REG_BIN_ORIGIN, 48'($urandom));
        end
      endcase
      random_phase(65);
      if (ph == 4) wait_drained();
      wait_drained();
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ----- files.f -----
hdl/hpb_pkg.sv
hdl/histogram_percentile_boundary_top.sv
hdl/hpb_checker.sv
tb/histogram_percentile_boundary_top_tb.sv
